// File: hw/rtl/tls13_psk_extension_parser_unit_assert.svh
// assertion macros for the psk extension parser
// used by the top level; depends on nothing
`ifndef TLS13_PSK_EXTENSION_PARSER_UNIT_ASSERT_SVH
`define TLS13_PSK_EXTENSION_PARSER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TPSK_ASSERT_NOW(label, clk_sig, rst_sig, ante, cons) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
		else $error("psk parser check failed");

// next-cycle implication, checked out of reset
`define TPSK_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
		else $error("psk parser check failed");

`endif

// File: hw/rtl/tpsk_pkg.sv
// shared types and constants of the psk extension parser
// no dependencies
package tpsk_pkg;

	localparam int TDATA_W = 80;
	localparam int TUSER_W = 3;
	localparam int CFG_W   = 6;

	typedef enum logic [2:0] {
		EV_ID_BYTE  = 3'd0,
		EV_ID_DONE  = 3'd1,
		EV_BND_BYTE = 3'd2,
		EV_BND_DONE = 3'd3,
		EV_ERROR    = 3'd4
	} event_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_TRUNC     = 3'd1,
		ST_NO_ID     = 3'd2,
		ST_NO_BND    = 3'd3,
		ST_ZERO_BND  = 3'd4,
		ST_NOT_FOUND = 3'd5
	} status_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  binder_length;
		logic [7:0]  payload_byte;
		logic [31:0] ticket_age;
		logic [15:0] identity_length;
		logic [5:0]  entry_index;
		event_t      event_res;
	} result_t;

endpackage

// File: hw/rtl/tls13_psk_extension_parser_unit.sv
// top level of the tls 1.3 pre_shared_key extension parser
// depends on tpsk_pkg, tpsk_parse_core, tpsk_out_stage and the assertion header
//
// channel    dir  handshake                      payload
// s_axis     in   s_axis_tvalid / s_axis_tready  tdata byte, tlast end of data
// m_axis     out  m_axis_tvalid / m_axis_tready  tdata result fields, tuser event
// cfg        in   cfg_wr_en                      cfg_wr_data wanted binder
//
// one byte a cycle unless the output stalls; requests pass input and result registers
// the rate is set by the combinational parse state update between the two registers
// arst_n clears the parse state and the wanted binder index, no clearing pass
// a full result register holds the input register, which still takes a request if empty
`include "tls13_psk_extension_parser_unit_assert.svh"

module tls13_psk_extension_parser_unit #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [7:0]                   s_axis_tdata,  // data_in
	input  logic                         s_axis_tlast,  // end_of_data
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// entry_index, identity_length, ticket_age, payload_byte, binder_length, status, zero fill
	output logic [tpsk_pkg::TDATA_W-1:0] m_axis_tdata,
	output logic [tpsk_pkg::TUSER_W-1:0] m_axis_tuser,  // event_res
	input  logic                         cfg_wr_en,
	input  logic [tpsk_pkg::CFG_W-1:0]   cfg_wr_data
);

	logic                       s1_valid_q;
	logic [7:0]                 byte_s1;
	logic                       last_s1;
	logic [tpsk_pkg::CFG_W-1:0] wanted_q;
	logic                       out_free;
	logic                       s1_adv;
	logic                       res_valid;
	tpsk_pkg::result_t          res;

	assign s1_adv        = s1_valid_q && out_free;
	assign s_axis_tready = !s1_valid_q || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			wanted_q   <= '0;
		end else begin
			if (s_axis_tready) begin
				s1_valid_q <= s_axis_tvalid;
			end
			if (cfg_wr_en) begin
				wanted_q <= cfg_wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	tpsk_parse_core #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (s1_adv),
		.byte_in  (byte_s1),
		.last_in  (last_s1),
		.wanted   (wanted_q),
		.res_valid(res_valid),
		.res      (res)
	);

	tpsk_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (s1_adv && res_valid),
		.res          (res),
		.m_axis_tready(m_axis_tready),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.out_free     (out_free)
	);

	// a stalled input request stays in the input register
	`TPSK_ASSERT_NEXT(a_s1_hold, clk, arst_n, s1_valid_q && !out_free, s1_valid_q)
	// a parsed request with a result shows up on the master side
	`TPSK_ASSERT_NEXT(a_res_lands, clk, arst_n, s1_adv && res_valid, m_axis_tvalid)
	// error results carry a status, others do not
	`TPSK_ASSERT_NOW(a_err_status, clk, arst_n,
		m_axis_tvalid && (m_axis_tuser == tpsk_pkg::EV_ERROR), m_axis_tdata[72:70] != 3'd0)
	`TPSK_ASSERT_NOW(a_ok_status, clk, arst_n,
		m_axis_tvalid && (m_axis_tuser != tpsk_pkg::EV_ERROR), m_axis_tdata[72:70] == 3'd0)

endmodule

// File: hw/rtl/tpsk_parse_core.sv
// byte-wise parse state machine of the psk extension
// depends on tpsk_pkg
module tpsk_parse_core #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  logic [7:0]              byte_in,
	input  logic                    last_in,
	input  logic [tpsk_pkg::CFG_W-1:0] wanted,
	output logic                    res_valid,
	output tpsk_pkg::result_t       res
);

	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int BW = $clog2(MAX_ENTRIES + 1);
	localparam int CW = BW + tpsk_pkg::CFG_W;

	typedef enum logic [3:0] {
		PH_IDL_HI, PH_IDL_LO, PH_IDN_HI, PH_IDN_LO, PH_IDBYTES, PH_AGE, PH_SKIP,
		PH_BL_HI, PH_BL_LO, PH_BLEN, PH_TAKE, PH_PASS, PH_DONE
	} phase_t;

	phase_t       phase_q, phase_d;
	logic [15:0]  list_len_q, list_len_d;
	logic [16:0]  consumed_q, consumed_d, consumed_inc;
	logic [15:0]  remain_q, remain_d, remain_dec;
	logic [15:0]  id_len_q, id_len_d;
	logic [31:0]  age_q, age_d, age_new;
	logic [IW-1:0] index_q, index_d;
	logic [1:0]   field_byte_q, field_byte_d;
	logic [BW-1:0] binder_cnt_q, binder_cnt_d;
	logic [7:0]   binder_len_q, binder_len_d;
	logic [7:0]   high_q, high_d;
	logic [15:0]  word;
	logic         binder_match;

	assign consumed_inc = (consumed_q == 17'h1FFFF) ? consumed_q : consumed_q + 17'd1;
	assign remain_dec   = remain_q - 16'd1;
	assign word         = {high_q, byte_in};
	assign age_new      = {age_q[23:0], byte_in};
	assign binder_match = (binder_cnt_q < BW'(MAX_ENTRIES)) &&
		(CW'(binder_cnt_q) == CW'(wanted));

	always_comb begin
		phase_d      = phase_q;
		list_len_d   = list_len_q;
		consumed_d   = consumed_q;
		remain_d     = remain_q;
		id_len_d     = id_len_q;
		age_d        = age_q;
		index_d      = index_q;
		field_byte_d = field_byte_q;
		binder_cnt_d = binder_cnt_q;
		binder_len_d = binder_len_q;
		high_d       = high_q;
		res_valid    = 1'b0;
		res          = '0;

		unique case (phase_q)
			PH_IDL_HI: begin
				high_d  = byte_in;
				phase_d = PH_IDL_LO;
			end
			PH_IDL_LO: begin
				list_len_d = word;
				consumed_d = '0;
				if (word == 16'd0) begin
					res_valid     = 1'b1;
					res.event_res = tpsk_pkg::EV_ERROR;
					res.status    = tpsk_pkg::ST_NO_ID;
					phase_d       = PH_DONE;
				end else begin
					phase_d = PH_IDN_HI;
				end
			end
			PH_IDN_HI: begin
				consumed_d = consumed_inc;
				high_d     = byte_in;
				phase_d    = PH_IDN_LO;
			end
			PH_IDN_LO: begin
				consumed_d = consumed_inc;
				id_len_d   = word;
				if (word == 16'd0) begin
					if (consumed_inc < {1'b0, list_len_q}) begin
						remain_d = 16'({1'b0, list_len_q} - consumed_inc);
						phase_d  = PH_SKIP;
					end else begin
						phase_d = PH_BL_HI;
					end
				end else begin
					remain_d = word;
					phase_d  = PH_IDBYTES;
				end
			end
			PH_IDBYTES: begin
				consumed_d          = consumed_inc;
				res_valid           = 1'b1;
				res.event_res       = tpsk_pkg::EV_ID_BYTE;
				res.entry_index     = 6'(index_q);
				res.identity_length = id_len_q;
				res.payload_byte    = byte_in;
				remain_d            = remain_dec;
				if (remain_dec == 16'd0) begin
					age_d        = '0;
					field_byte_d = '0;
					phase_d      = PH_AGE;
				end
			end
			PH_AGE: begin
				consumed_d = consumed_inc;
				age_d      = age_new;
				if (field_byte_q == 2'd3) begin
					res_valid           = 1'b1;
					res.event_res       = tpsk_pkg::EV_ID_DONE;
					res.entry_index     = 6'(index_q);
					res.identity_length = id_len_q;
					res.ticket_age      = age_new;
					index_d = (index_q == IW'(MAX_ENTRIES - 1)) ? '0 : index_q + 1'b1;
					field_byte_d = '0;
					if (consumed_inc >= {1'b0, list_len_q}) begin
						phase_d = PH_BL_HI;
					end else begin
						phase_d = PH_IDN_HI;
					end
				end else begin
					field_byte_d = field_byte_q + 2'd1;
				end
			end
			PH_SKIP: begin
				consumed_d = consumed_inc;
				remain_d   = remain_dec;
				if (remain_dec == 16'd0) begin
					phase_d = PH_BL_HI;
				end
			end
			PH_BL_HI: begin
				high_d  = byte_in;
				phase_d = PH_BL_LO;
			end
			PH_BL_LO: begin
				list_len_d = word;
				if (word == 16'd0) begin
					res_valid     = 1'b1;
					res.event_res = tpsk_pkg::EV_ERROR;
					res.status    = tpsk_pkg::ST_NO_BND;
					phase_d       = PH_DONE;
				end else begin
					binder_cnt_d = '0;
					phase_d      = PH_BLEN;
				end
			end
			PH_BLEN: begin
				if (byte_in == 8'd0) begin
					res_valid     = 1'b1;
					res.event_res = tpsk_pkg::EV_ERROR;
					res.status    = tpsk_pkg::ST_ZERO_BND;
					phase_d       = PH_DONE;
				end else begin
					binder_len_d = byte_in;
					remain_d     = {8'd0, byte_in};
					phase_d      = binder_match ? PH_TAKE : PH_PASS;
				end
			end
			PH_TAKE: begin
				remain_d          = remain_dec;
				res_valid         = 1'b1;
				res.entry_index   = 6'(binder_cnt_q);
				res.payload_byte  = byte_in;
				res.binder_length = binder_len_q;
				if (remain_dec == 16'd0) begin
					res.event_res = tpsk_pkg::EV_BND_DONE;
					phase_d       = PH_DONE;
				end else begin
					res.event_res = tpsk_pkg::EV_BND_BYTE;
				end
			end
			PH_PASS: begin
				remain_d = remain_dec;
				if (remain_dec == 16'd0) begin
					if (binder_cnt_q < BW'(MAX_ENTRIES)) begin
						binder_cnt_d = binder_cnt_q + 1'b1;
					end
					phase_d = PH_BLEN;
				end
			end
			PH_DONE: begin
				phase_d = PH_DONE;
			end
			default: begin
				phase_d = PH_DONE;
			end
		endcase

		if (last_in) begin
			if (phase_q != PH_DONE && phase_d != PH_DONE) begin
				res_valid     = 1'b1;
				res           = '0;
				res.event_res = tpsk_pkg::EV_ERROR;
				res.status    = (phase_d == PH_BLEN) ? tpsk_pkg::ST_NOT_FOUND
					: tpsk_pkg::ST_TRUNC;
			end
			phase_d      = PH_IDL_HI;
			list_len_d   = '0;
			consumed_d   = '0;
			remain_d     = '0;
			id_len_d     = '0;
			age_d        = '0;
			index_d      = '0;
			field_byte_d = '0;
			binder_cnt_d = '0;
			binder_len_d = '0;
			high_d       = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDL_HI;
			list_len_q   <= '0;
			consumed_q   <= '0;
			remain_q     <= '0;
			id_len_q     <= '0;
			age_q        <= '0;
			index_q      <= '0;
			field_byte_q <= '0;
			binder_cnt_q <= '0;
			binder_len_q <= '0;
			high_q       <= '0;
		end else if (step) begin
			phase_q      <= phase_d;
			list_len_q   <= list_len_d;
			consumed_q   <= consumed_d;
			remain_q     <= remain_d;
			id_len_q     <= id_len_d;
			age_q        <= age_d;
			index_q      <= index_d;
			field_byte_q <= field_byte_d;
			binder_cnt_q <= binder_cnt_d;
			binder_len_q <= binder_len_d;
			high_q       <= high_d;
		end
	end

endmodule

// File: hw/rtl/tpsk_out_stage.sv
// result register on the master side of the psk parser
// depends on tpsk_pkg
module tpsk_out_stage (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  tpsk_pkg::result_t            res,
	input  logic                         m_axis_tready,
	output logic                         m_axis_tvalid,
	output logic [tpsk_pkg::TDATA_W-1:0] m_axis_tdata,
	output logic [tpsk_pkg::TUSER_W-1:0] m_axis_tuser,
	output logic                         out_free
);

	logic              valid_q;
	tpsk_pkg::result_t res_q;

	assign out_free      = !valid_q || m_axis_tready;
	assign m_axis_tvalid = valid_q;
	assign m_axis_tuser  = res_q.event_res;
	assign m_axis_tdata  = {7'd0, res_q.status, res_q.binder_length, res_q.payload_byte,
		res_q.ticket_age, res_q.identity_length, res_q.entry_index};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule
